[src/median_hue_color_rejector_macros.svh]
// ----------------------------------------------------------------------------
// Median hue color rejector: assertion macros
// Shared property wrappers for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_HUE_COLOR_REJECTOR_MACROS_SVH
`define MEDIAN_HUE_COLOR_REJECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MHCR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mhcr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define MHCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mhcr: next-cycle check failed");

`endif

[src/mhcr_pkg.sv]
// ----------------------------------------------------------------------------
// Median hue color rejector: package
// Shared widths, reset values and register indexes.
// ----------------------------------------------------------------------------
package mhcr_pkg;

  localparam int HUE_W          = 9;
  localparam int DATA_W         = 16;
  localparam int CFG_ADDR_W     = 3;
  localparam int WINDOW_LEN_DEF = 5;

  typedef logic [HUE_W-1:0] hue_t;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ALLIANCE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RED_LOW   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RED_HIGH  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLUE_LOW  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLUE_HIGH = 3'd4;

  // reset values
  localparam logic ALLIANCE_RST  = 1'b1;
  localparam hue_t RED_LOW_RST   = 9'd20;
  localparam hue_t RED_HIGH_RST  = 9'd340;
  localparam hue_t BLUE_LOW_RST  = 9'd200;
  localparam hue_t BLUE_HIGH_RST = 9'd250;

endpackage

[src/mhcr_median.sv]
// ----------------------------------------------------------------------------
// Median hue color rejector: window median
// Rank-select median over the filled part of the hue window.
// ----------------------------------------------------------------------------
module mhcr_median
  import mhcr_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int FILL_W     = $clog2(WINDOW_LEN + 1)
) (
  input  hue_t              win_i [WINDOW_LEN],
  input  logic [FILL_W-1:0] fill_i,
  output hue_t              med_o
);

  logic [FILL_W-1:0] mid_rank;
  logic [FILL_W-1:0] rank [WINDOW_LEN];
  logic              slot_valid [WINDOW_LEN];

  assign mid_rank = fill_i >> 1;

  // Rank each valid slot; ties break on slot position so ranks are unique.
  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      slot_valid[i] = (FILL_W'(i) < fill_i);
      rank[i] = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if (j != i && FILL_W'(j) < fill_i &&
            ((win_i[j] < win_i[i]) || (win_i[j] == win_i[i] && j < i))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
  end

  // Exactly one valid slot holds the middle rank; none when empty.
  always_comb begin
    med_o = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (slot_valid[i] && rank[i] == mid_rank) begin
        med_o = med_o | win_i[i];
      end
    end
  end

endmodule

[src/median_hue_color_rejector.sv]
// ----------------------------------------------------------------------------
// Median hue color rejector: top level
// Sliding-window median of sensor hue with red/blue classing and eject.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the output is not stalled and returns
// one result per request. A request with the near flag set writes its
// hue into the window (oldest slot replaced once full); the window register
// update at acceptance is the only loop, so back-to-back requests stream
// with no bubbles. The median of the updated window (upper median while
// filling, 0 when empty) is found by a rank-select compare network and is
// registered with its red/blue class and the eject flag. Class and eject
// are 0 when the request has no object near. A stalled result holds in the
// output register while one more request is accepted; the input then
// stalls. Write configuration only while no request is in flight.
// ----------------------------------------------------------------------------
`include "median_hue_color_rejector_macros.svh"

module median_hue_color_rejector
  import mhcr_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // [8:0] hue_sample, rest zero
  input  logic                  in_tuser,   // [0] object_near
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,  // [8:0] median_hue, rest zero
  output logic [2:0]            out_tuser,  // [0] seen_red, [1] seen_blue, [2] eject
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [HUE_W-1:0]      cfg_wdata
);

  localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(WINDOW_LEN);

  // configuration registers
  logic alliance_r;
  hue_t red_low_r, red_high_r, blue_low_r, blue_high_r;

  // window state
  hue_t              hue_win_r [WINDOW_LEN];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  // stage one: request registered, window already updated
  logic s1_valid_r;
  logic near_r;

  // result register
  logic out_valid_r;
  hue_t out_med_r;
  logic out_red_r, out_blue_r, out_eject_r;

  logic in_accept, push, out_free, s1_adv;
  hue_t in_hue, med;
  logic is_red, is_blue, do_eject;

  assign in_hue    = in_tdata[HUE_W-1:0];
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_accept = in_tvalid && in_tready;
  assign push      = in_accept && in_tuser;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alliance_r  <= ALLIANCE_RST;
      red_low_r   <= RED_LOW_RST;
      red_high_r  <= RED_HIGH_RST;
      blue_low_r  <= BLUE_LOW_RST;
      blue_high_r <= BLUE_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ALLIANCE:  alliance_r  <= cfg_wdata[0];
        CFG_RED_LOW:   red_low_r   <= cfg_wdata;
        CFG_RED_HIGH:  red_high_r  <= cfg_wdata;
        CFG_BLUE_LOW:  blue_low_r  <= cfg_wdata;
        CFG_BLUE_HIGH: blue_high_r <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---- window update at acceptance ----
  // Slots fill in order, so while filling the valid entries are 0..fill-1.
  assign slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
  assign fill_nxt = (fill_r == FULL_FILL) ? fill_r : fill_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        hue_win_r[i] <= '0;
      end
      fill_r <= '0;
      slot_r <= '0;
    end else if (push) begin
      hue_win_r[slot_r] <= in_hue;
      fill_r            <= fill_nxt;
      slot_r            <= slot_nxt;
    end
  end

  // ---- stage one ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      near_r <= in_tuser;
    end
  end

  // ---- median and classing ----
  mhcr_median #(
    .WINDOW_LEN (WINDOW_LEN),
    .FILL_W     (FILL_W)
  ) u_median (
    .win_i  (hue_win_r),
    .fill_i (fill_r),
    .med_o  (med)
  );

  assign is_red   = near_r && ((med < red_low_r) || (med > red_high_r));
  assign is_blue  = near_r && ((med > blue_low_r) && (med < blue_high_r));
  // own alliance red: eject blue; own alliance blue: eject red
  assign do_eject = alliance_r ? is_red : is_blue;

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_med_r   <= med;
      out_red_r   <= is_red;
      out_blue_r  <= is_blue;
      out_eject_r <= do_eject;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(DATA_W - HUE_W){1'b0}}, out_med_r};
  assign out_tuser  = {out_eject_r, out_blue_r, out_red_r};

  // ---- checks ----
  `MHCR_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FULL_FILL)
  `MHCR_ASSERT_IMPL(a_slot_bound, clk, rst_n, 1'b1, slot_r <= LAST_SLOT)
  `MHCR_ASSERT_IMPL(a_eject_has_class, clk, rst_n, out_valid_r && out_eject_r,
                    out_red_r || out_blue_r)
  `MHCR_ASSERT_IMPL(a_hold_input, clk, rst_n, s1_valid_r && !out_free, !in_tready)
  `MHCR_ASSERT_NEXT(a_fill_grows, clk, rst_n, push && fill_r != FULL_FILL,
                    fill_r == $past(fill_r) + 1'b1)

endmodule
